// ----- rtl/core/cmc_pkg.sv -----
// Shared types, request codes and turn tables for the cube move and coordinates core.
package cmc_pkg;

  localparam int unsigned NumCorners = 8;
  localparam int unsigned NumEdges   = 12;
  localparam int unsigned NumFaces   = 6;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  // Request codes carried in the low bits of the input transaction
  localparam logic [1:0] REQ_SOLVE = 2'd0;
  localparam logic [1:0] REQ_TURN  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef enum logic [1:0] {
    CMD_SOLVE = 2'd0,
    CMD_TURN  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  face;
  } cmd_t;

  // Slot i takes the cubie of slot TABLE[face][i]
  localparam logic [2:0] TurnCp [NumFaces][NumCorners] = '{
    '{3'd3, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd4, 3'd1, 3'd2, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3},
    '{3'd1, 3'd5, 3'd2, 3'd3, 3'd0, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7, 3'd4},
    '{3'd0, 3'd2, 3'd6, 3'd3, 3'd4, 3'd1, 3'd5, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd7, 3'd4, 3'd5, 3'd2, 3'd6}
  };

  localparam logic [1:0] TurnCo [NumFaces][NumCorners] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1}
  };

  localparam logic [3:0] TurnEp [NumFaces][NumEdges] = '{
    '{4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd8, 4'd1, 4'd2, 4'd3, 4'd11, 4'd5, 4'd6, 4'd7, 4'd4, 4'd9, 4'd10, 4'd0},
    '{4'd0, 4'd9, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6, 4'd7, 4'd1, 4'd5, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd10, 4'd3, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8, 4'd2, 4'd6, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd11, 4'd4, 4'd5, 4'd6, 4'd10, 4'd8, 4'd9, 4'd3, 4'd7}
  };

  localparam logic TurnEo [NumFaces][NumEdges] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}
  };

endpackage

// ----- rtl/core/cmc_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
module cmc_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [1:0] req_type, [4:2] face, [7:5] zero
  input  logic [cmc_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output cmc_pkg::cmd_t                 cmd_o
);

  logic [1:0] req_type;
  logic [2:0] face;

  assign req_type = s_axis_tdata_i[1:0];
  assign face     = s_axis_tdata_i[4:2];

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

  always_comb begin
    cmd_o.face = face;
    unique case (req_type)
      cmc_pkg::REQ_SOLVE: cmd_o.kind = cmc_pkg::CMD_SOLVE;
      cmc_pkg::REQ_TURN: begin
        // a face past the last one turns nothing
        if (face < 3'(cmc_pkg::NumFaces)) begin
          cmd_o.kind = cmc_pkg::CMD_TURN;
        end else begin
          cmd_o.kind = cmc_pkg::CMD_QUERY;
        end
      end
      default: cmd_o.kind = cmc_pkg::CMD_QUERY;
    endcase
  end

endmodule

// ----- rtl/core/cmc_queue.sv -----
// Short command queue between the front end and the back end.
module cmc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmc_pkg::cmd_t  cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output cmc_pkg::cmd_t  cmd_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/cmc_back.sv -----
// Back end: holds the cube state, applies commands and works out the coordinates.
module cmc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  cmc_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [12:0] twist_coord, [24:13] flip_coord, [40:25] corner_perm_coord,
  // [69:41] edge_perm_coord, [71:70] zero
  output logic [cmc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned NC = cmc_pkg::NumCorners;
  localparam int unsigned NE = cmc_pkg::NumEdges;
  localparam int unsigned NF = cmc_pkg::NumFaces;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_OUT  = 3'b100
  } back_state_e;

  localparam logic [3:0] FirstStep = 4'(NE - 1);
  localparam logic [3:0] LastCornerStep = 4'(NC - 1);
  // twist digits are taken while the step runs from the top down to this one
  localparam logic [3:0] LastTwistStep = 4'(NE - NC);

  back_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;

  logic [2:0] cp_q [NC];
  logic [1:0] ct_q [NC];
  logic [3:0] ep_q [NE];
  logic       eo_q [NE];

  logic [2:0] cp_d [NC];
  logic [1:0] ct_d [NC];
  logic [3:0] ep_d [NE];
  logic       eo_d [NE];

  logic [12:0] tw_q, tw_d;
  logic [15:0] cperm_q, cperm_d;
  logic [28:0] eperm_q, eperm_d;
  logic [11:0] flip;

  logic        load;
  logic [2:0]  sum3;
  logic [3:0]  ep_k;
  logic [2:0]  cp_k;
  logic [3:0]  cnt_e;
  logic [2:0]  cnt_c;
  logic [2:0]  tw_idx;
  logic [3:0]  tw_pos;
  logic [28:0] e_sum;
  logic [32:0] e_prod;
  logic [15:0] c_sum;
  logic [18:0] c_prod;
  logic [14:0] tw_ext;

  assign load      = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = load;

  // Apply the command to the cube state
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cp_d[i] = cp_q[i];
      ct_d[i] = ct_q[i];
    end
    for (int i = 0; i < NE; i++) begin
      ep_d[i] = ep_q[i];
      eo_d[i] = eo_q[i];
    end
    sum3 = '0;
    if (load) begin
      case (cmd_i.kind)
        cmc_pkg::CMD_SOLVE: begin
          for (int i = 0; i < NC; i++) begin
            cp_d[i] = 3'(i);
            ct_d[i] = '0;
          end
          for (int i = 0; i < NE; i++) begin
            ep_d[i] = 4'(i);
            eo_d[i] = 1'b0;
          end
        end
        cmc_pkg::CMD_TURN: begin
          for (int f = 0; f < NF; f++) begin
            if (cmd_i.face == 3'(f)) begin
              for (int i = 0; i < NC; i++) begin
                cp_d[i] = cp_q[cmc_pkg::TurnCp[f][i]];
                sum3    = 3'(ct_q[cmc_pkg::TurnCp[f][i]]) + 3'(cmc_pkg::TurnCo[f][i]);
                ct_d[i] = (sum3 >= 3'd3) ? 2'(sum3 - 3'd3) : sum3[1:0];
              end
              for (int i = 0; i < NE; i++) begin
                ep_d[i] = ep_q[cmc_pkg::TurnEp[f][i]];
                eo_d[i] = eo_q[cmc_pkg::TurnEp[f][i]] ^ cmc_pkg::TurnEo[f][i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // One inversion-count step for edges and corners, one twist digit
  always_comb begin
    ep_k   = ep_q[step_q];
    cp_k   = cp_q[step_q[2:0]];
    cnt_e  = '0;
    cnt_c  = '0;
    for (int j = 0; j < NE; j++) begin
      if ((4'(j) < step_q) && (ep_q[j] > ep_k)) begin
        cnt_e = cnt_e + 4'd1;
      end
    end
    for (int j = 0; j < NC; j++) begin
      if ((4'(j) < step_q) && (cp_q[j] > cp_k)) begin
        cnt_c = cnt_c + 3'd1;
      end
    end
    e_sum  = eperm_q + 29'(cnt_e);
    e_prod = 33'(e_sum) * 33'(step_q);
    c_sum  = cperm_q + 16'(cnt_c);
    c_prod = 19'(c_sum) * 19'(step_q[2:0]);
    tw_pos = FirstStep - step_q;
    tw_idx = tw_pos[2:0];
    tw_ext = 15'({tw_q, 1'b0}) + 15'(tw_q) + 15'(ct_q[tw_idx]);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    tw_d    = tw_q;
    cperm_d = cperm_q;
    eperm_d = eperm_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_STEP;
          step_d  = FirstStep;
          tw_d    = '0;
          cperm_d = '0;
          eperm_d = '0;
        end
      end
      ST_STEP: begin
        eperm_d = e_prod[28:0];
        if (step_q <= LastCornerStep) begin
          cperm_d = c_prod[15:0];
        end
        if (step_q >= LastTwistStep) begin
          tw_d = tw_ext[12:0];
        end
        step_d = step_q - 4'd1;
        if (step_q == 4'd1) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      for (int i = 0; i < NC; i++) begin
        cp_q[i] <= 3'(i);
        ct_q[i] <= '0;
      end
      for (int i = 0; i < NE; i++) begin
        ep_q[i] <= 4'(i);
        eo_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cp_q    <= cp_d;
      ct_q    <= ct_d;
      ep_q    <= ep_d;
      eo_q    <= eo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tw_q    <= tw_d;
    cperm_q <= cperm_d;
    eperm_q <= eperm_d;
  end

  // edge slot 0 is the most significant flip bit
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      flip[NE-1-i] = eo_q[i];
    end
  end

  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {2'b00, eperm_q, cperm_q, flip, tw_q};

  logic [NC-1:0] corner_seen;
  logic [NE-1:0] edge_seen;
  logic          twist_ok;

  always_comb begin
    corner_seen = '0;
    edge_seen   = '0;
    twist_ok    = 1'b1;
    for (int i = 0; i < NC; i++) begin
      corner_seen = corner_seen | (NC'(1) << cp_q[i]);
      if (ct_q[i] == 2'd3) begin
        twist_ok = 1'b0;
      end
    end
    for (int i = 0; i < NE; i++) begin
      edge_seen = edge_seen | (NE'(1) << ep_q[i]);
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |-> (step_q >= 4'd1) && (step_q <= FirstStep))
    else $error("coordinate step counter out of range");

  a_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) && (step_q == 4'd1) |=> m_axis_tvalid_o)
    else $error("result not presented after the last step");

  a_corner_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_seen == {NC{1'b1}})
    else $error("corner slots no longer hold a permutation");

  a_edge_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_seen == {NE{1'b1}})
    else $error("edge slots no longer hold a permutation");

  a_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    twist_ok)
    else $error("corner twist left the range 0 to 2");

endmodule

// ----- rtl/core/cube_move_and_coordinates_core.sv -----
// Top level of the cube move and coordinates core.
//
// The slave stream carries one request per transaction: tdata[1:0] is the
// request (solve, turn, query) and tdata[4:2] the face turned clockwise.
// Every request gives exactly one transaction on the master stream holding
// the twist, flip, corner permutation and edge permutation coordinates of
// the cube after the request has been carried out.
// The front end classifies requests into a short command queue; the back
// end pops one command, updates the cube state as it pops, then runs
// eleven serial steps of the inversion count (one shared multiply-add per
// permutation) before presenting the result. The back end pops no new
// command until the result has been taken, so items do not overlap; the
// eleven-step inversion count sets the pace. Requests keep entering the
// queue while a result waits.
// Reset puts the cube in the solved state and empties the queue. While the
// receiver holds tready low the result stays on the port unchanged, the
// back end stops, and once the queue is full the slave tready drops.
module cube_move_and_coordinates_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] req_type, [4:2] face, [7:5] zero
  input  logic [cmc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [12:0] twist_coord, [24:13] flip_coord, [40:25] corner_perm_coord,
  // [69:41] edge_perm_coord, [71:70] zero
  output logic [cmc_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic          push;
  logic          queue_full;
  logic          cmd_valid;
  logic          cmd_pop;
  cmc_pkg::cmd_t push_cmd;
  cmc_pkg::cmd_t head_cmd;

  cmc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  cmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd),
    .pop_i   (cmd_pop)
  );

  cmc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- bench/tb_cube_move_and_coordinates_core.sv -----
// Self-checking bench for the cube move and coordinates core: directed table, then random moves.
module tb_cube_move_and_coordinates_core;

  typedef struct packed {
    logic [28:0] edge_perm;
    logic [15:0] corner_perm;
    logic [11:0] flip;
    logic [12:0] twist;
  } coords_t;

  typedef struct packed {
    logic [1:0] req;
    logic [2:0] face;
    logic       known;
    coords_t    want;
  } request_row_t;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [2:0] FACE_U      = 3'd0;
  localparam logic [2:0] FACE_R      = 3'd1;
  localparam logic [2:0] FACE_F      = 3'd2;
  localparam logic [2:0] FACE_D      = 3'd3;
  localparam logic [2:0] FACE_L      = 3'd4;
  localparam logic [2:0] FACE_B      = 3'd5;
  localparam logic [2:0] FACE_BAD_LO = 3'd6;
  localparam logic [2:0] FACE_BAD_HI = 3'd7;

  localparam coords_t     SolvedCoords = '0;
  localparam int unsigned ClockPeriod  = 10;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned RandomItems  = 1030;
  localparam int unsigned DrainCycles  = 30;
  localparam int unsigned StallLimit   = 400;
  localparam int unsigned NumRows      = 22;

  // Slot i takes the cubie of slot FROM[face][i], then adds the face's twist or flip
  localparam int unsigned CornerFrom [6][8] = '{
    '{3, 0, 1, 2, 4, 5, 6, 7},
    '{4, 1, 2, 0, 7, 5, 6, 3},
    '{1, 5, 2, 3, 0, 4, 6, 7},
    '{0, 1, 2, 3, 5, 6, 7, 4},
    '{0, 2, 6, 3, 4, 1, 5, 7},
    '{0, 1, 3, 7, 4, 5, 2, 6}
  };
  localparam int unsigned CornerAdd [6][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 0, 0, 1, 1, 0, 0, 2},
    '{1, 2, 0, 0, 2, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 2, 0, 0, 2, 1, 0},
    '{0, 0, 1, 2, 0, 0, 2, 1}
  };
  localparam int unsigned EdgeFrom [6][12] = '{
    '{3, 0, 1, 2, 4, 5, 6, 7, 8, 9, 10, 11},
    '{8, 1, 2, 3, 11, 5, 6, 7, 4, 9, 10, 0},
    '{0, 9, 2, 3, 4, 8, 6, 7, 1, 5, 10, 11},
    '{0, 1, 2, 3, 5, 6, 7, 4, 8, 9, 10, 11},
    '{0, 1, 10, 3, 4, 5, 9, 7, 8, 2, 6, 11},
    '{0, 1, 2, 11, 4, 5, 6, 10, 8, 9, 3, 7}
  };
  localparam int unsigned EdgeAdd [6][12] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 1, 0, 0, 1, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 1}
  };

  localparam request_row_t DirectedRows [NumRows] = '{
    '{cmc_pkg::REQ_QUERY, FACE_U,      1'b1, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_BAD_LO, 1'b1, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_BAD_HI, 1'b1, SolvedCoords},
    '{REQ_SPARE,          FACE_B,      1'b1, SolvedCoords},
    '{cmc_pkg::REQ_SOLVE, FACE_BAD_HI, 1'b1, SolvedCoords},
    '{cmc_pkg::REQ_QUERY, FACE_BAD_HI, 1'b1, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_U,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_R,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_F,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_D,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_L,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_B,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_QUERY, FACE_BAD_LO, 1'b0, SolvedCoords},
    '{REQ_SPARE,          FACE_U,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_BAD_HI, 1'b0, SolvedCoords},
    '{cmc_pkg::REQ_SOLVE, FACE_B,      1'b1, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_F,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_F,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_F,      1'b0, SolvedCoords},
    // four quarter turns of one face bring the cube back to solved
    '{cmc_pkg::REQ_TURN,  FACE_F,      1'b1, SolvedCoords},
    '{cmc_pkg::REQ_TURN,  FACE_R,      1'b0, SolvedCoords},
    '{cmc_pkg::REQ_SOLVE, FACE_U,      1'b1, SolvedCoords}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [cmc_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [cmc_pkg::OutDataW-1:0] m_axis_tdata;

  // Predicted cube state
  int unsigned cube_cp [8];
  int unsigned cube_co [8];
  int unsigned cube_ep [12];
  int unsigned cube_eo [12];

  coords_t     pending_coords [$];
  int unsigned n_fail      = 0;
  int unsigned idle_cycles = 0;
  bit          send_busy   = 1'b0;

  cube_move_and_coordinates_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned inversion_code(input int unsigned perm [12],
                                                 input int unsigned n);
    int unsigned code;
    int unsigned cnt;
    code = 0;
    for (int i = n - 1; i > 0; i--) begin
      cnt = 0;
      for (int j = 0; j < i; j++) begin
        if (perm[j] > perm[i]) cnt++;
      end
      code = (code + cnt) * i;
    end
    return code;
  endfunction

  function automatic void solve_cube();
    for (int i = 0; i < 8; i++) begin
      cube_cp[i] = i;
      cube_co[i] = 0;
    end
    for (int i = 0; i < 12; i++) begin
      cube_ep[i] = i;
      cube_eo[i] = 0;
    end
  endfunction

  // Carry out one request on the predicted cube and return its coordinates
  function automatic coords_t advance_cube(input logic [1:0] req, input logic [2:0] face);
    int unsigned next_cp [8];
    int unsigned next_co [8];
    int unsigned next_ep [12];
    int unsigned next_eo [12];
    int unsigned cp_pad [12];
    int unsigned tw;
    int unsigned fl;
    coords_t     res;
    if (req == cmc_pkg::REQ_SOLVE) begin
      solve_cube();
    end else if (req == cmc_pkg::REQ_TURN && face <= FACE_B) begin
      for (int i = 0; i < 8; i++) begin
        next_cp[i] = cube_cp[CornerFrom[face][i]];
        next_co[i] = (cube_co[CornerFrom[face][i]] + CornerAdd[face][i]) % 3;
      end
      for (int i = 0; i < 12; i++) begin
        next_ep[i] = cube_ep[EdgeFrom[face][i]];
        next_eo[i] = cube_eo[EdgeFrom[face][i]] ^ EdgeAdd[face][i];
      end
      cube_cp = next_cp;
      cube_co = next_co;
      cube_ep = next_ep;
      cube_eo = next_eo;
    end
    tw = 0;
    fl = 0;
    for (int i = 0; i < 8; i++) tw = tw * 3 + cube_co[i];
    for (int i = 0; i < 12; i++) fl = (fl << 1) | cube_eo[i];
    for (int i = 0; i < 12; i++) cp_pad[i] = (i < 8) ? cube_cp[i] : 0;
    res.twist       = tw[12:0];
    res.flip        = fl[11:0];
    res.corner_perm = 16'(inversion_code(cp_pad, 8));
    res.edge_perm   = 29'(inversion_code(cube_ep, 12));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    n_fail++;
  endtask

  task automatic check_result(input logic [cmc_pkg::OutDataW-1:0] word);
    coords_t got;
    coords_t want;
    got = word[$bits(coords_t)-1:0];
    if (pending_coords.size() == 0) begin
      report_mismatch("result with no request pending", got.twist, 0);
    end else begin
      want = pending_coords.pop_front();
      if (got.twist !== want.twist)
        report_mismatch("twist_coord", got.twist, want.twist);
      if (got.flip !== want.flip)
        report_mismatch("flip_coord", got.flip, want.flip);
      if (got.corner_perm !== want.corner_perm)
        report_mismatch("corner_perm_coord", got.corner_perm, want.corner_perm);
      if (got.edge_perm !== want.edge_perm)
        report_mismatch("edge_perm_coord", got.edge_perm, want.edge_perm);
    end
  endtask

  // Offer one request, hold it until the transaction, then record its coordinates
  task automatic send_request(input logic [1:0] req, input logic [2:0] face,
                              input logic known, input coords_t want);
    int unsigned gap;
    coords_t     predicted;
    gap = send_busy ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, face, req};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_cube(req, face);
    pending_coords.push_back(known ? want : predicted);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_coords.size() != 0);
  endtask

  // Sender and end of run
  initial begin
    int unsigned  pick;
    logic [1:0]   req;
    logic [2:0]   face;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    solve_cube();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumRows; k++) begin
      send_request(DirectedRows[k].req, DirectedRows[k].face, DirectedRows[k].known,
                   DirectedRows[k].want);
    end
    hold_until_drained();

    for (int k = 0; k < RandomItems; k++) begin
      if (k % 64 == 0) send_busy = ($urandom_range(0, 3) == 0);
      if (k == RandomItems / 3 || k == 2 * RandomItems / 3) hold_until_drained();
      pick = $urandom_range(0, 99);
      face = 3'($urandom_range(0, 7));
      // mostly legal turns so the cube wanders far from solved
      if (pick < 3) begin
        req = cmc_pkg::REQ_SOLVE;
      end else if (pick < 10) begin
        req = cmc_pkg::REQ_QUERY;
      end else if (pick < 13) begin
        req = REQ_SPARE;
      end else if (pick < 17) begin
        req  = cmc_pkg::REQ_TURN;
        face = $urandom_range(0, 1) ? FACE_BAD_HI : FACE_BAD_LO;
      end else begin
        req  = cmc_pkg::REQ_TURN;
        face = 3'($urandom_range(FACE_U, FACE_B));
      end
      send_request(req, face, 1'b0, SolvedCoords);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_coords.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver with random back-pressure
  initial begin
    int unsigned stall;
    int unsigned n_seen;
    bit          recv_busy;
    m_axis_tready = 1'b0;
    n_seen        = 0;
    recv_busy     = 1'b0;
    @(posedge clk_i);
    forever begin
      if (n_seen % 64 == 0) recv_busy = ($urandom_range(0, 3) == 0);
      stall = recv_busy ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
      n_seen++;
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
